// ===== hw/rtl/smft_pkg.sv =====
`timescale 1ns / 1ps
// Package for the sorted multiset floor-take block.
// Holds the result codes, the controller states and the command and status structs.
// Used by smft_ctrl, smft_datapath and sorted_multiset_floor_take.
package smft_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned OCC_W   = 11;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_TAKE   = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_TAKEN    = 2'd2,
    ST_NOMATCH  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE
  } ctrl_state_e;

  typedef struct packed {
    logic    load_take;
    logic    do_insert;
    logic    scan;
    logic    fetch_last;
    logic    move;
    logic    emit;
    status_e status;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic scan_done;
    logic found;
  } dp_stat_t;

endpackage

// ===== hw/rtl/smft_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the sorted multiset floor-take block.
// Sequences inserts, the take scan and the hole fill; depends on smft_pkg.
module smft_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic            cmd_i,
  input  smft_pkg::dp_stat_t stat_i,
  output smft_pkg::dp_cmd_t  cmd_o,
  output logic            busy
);

  smft_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smft_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.status = smft_pkg::ST_INSERTED;
    case (state_q)
      smft_pkg::S_IDLE: begin
        if (start) begin
          if (cmd_i == smft_pkg::CMD_TAKE) begin
            if (stat_i.empty) begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = smft_pkg::ST_NOMATCH;
            end else begin
              cmd_o.load_take = 1'b1;
              state_d         = smft_pkg::S_SCAN;
            end
          end else begin
            cmd_o.emit = 1'b1;
            if (stat_i.full) begin
              cmd_o.status = smft_pkg::ST_FULL;
            end else begin
              cmd_o.do_insert = 1'b1;
              cmd_o.status    = smft_pkg::ST_INSERTED;
            end
          end
        end
      end
      smft_pkg::S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          if (stat_i.found) begin
            cmd_o.fetch_last = 1'b1;
            state_d          = smft_pkg::S_MOVE;
          end else begin
            cmd_o.emit   = 1'b1;
            cmd_o.status = smft_pkg::ST_NOMATCH;
            state_d      = smft_pkg::S_IDLE;
          end
        end
      end
      smft_pkg::S_MOVE: begin
        cmd_o.move   = 1'b1;
        cmd_o.emit   = 1'b1;
        cmd_o.status = smft_pkg::ST_TAKEN;
        state_d      = smft_pkg::S_IDLE;
      end
      default: begin
        state_d = smft_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != smft_pkg::S_IDLE);

endmodule

// ===== hw/rtl/smft_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the sorted multiset floor-take block: value store, count, scan and result registers.
// The store is kept unordered; a take scans it and fills the hole with the last entry.
// Depends on smft_pkg and is driven by smft_ctrl.
module smft_datapath #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [smft_pkg::VALUE_W-1:0]   value_i,
  input  smft_pkg::dp_cmd_t              cmd_i,
  output smft_pkg::dp_stat_t             stat_o,
  output logic                           done_o,
  output logic [1:0]                     status_o,
  output logic [smft_pkg::VALUE_W-1:0]   taken_value_o,
  output logic [smft_pkg::OCC_W-1:0]     occupancy_o
);

  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned AddrW = $clog2(CAPACITY);

  logic [smft_pkg::VALUE_W-1:0] mem_q [CAPACITY];

  logic [CntW-1:0]              cnt_q, cnt_d, last_cnt;
  logic [CntW-1:0]              addr_q;
  logic                         rvalid_q;
  logic                         found_q;
  logic [smft_pkg::VALUE_W-1:0] lim_q;
  logic [smft_pkg::VALUE_W-1:0] best_q;
  logic [AddrW-1:0]             best_idx_q;
  logic [AddrW-1:0]             rd_idx_q;
  logic [smft_pkg::VALUE_W-1:0] rdata_q;
  logic                         done_q;
  smft_pkg::status_e            status_q;
  logic [smft_pkg::VALUE_W-1:0] taken_q;
  logic [smft_pkg::OCC_W-1:0]   occ_q;

  logic                         more;
  logic                         issue;
  logic                         hit;
  logic                         rd_en;
  logic [AddrW-1:0]             rd_addr;

  assign more     = (addr_q < cnt_q);
  assign issue    = cmd_i.scan && more;
  assign hit      = rvalid_q && (rdata_q <= lim_q) && (!found_q || (rdata_q > best_q));
  assign last_cnt = cnt_q - CntW'(1);
  assign rd_en    = cmd_i.fetch_last || issue;
  assign rd_addr  = cmd_i.fetch_last ? last_cnt[AddrW-1:0] : addr_q[AddrW-1:0];

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.do_insert) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (cmd_i.move) begin
      cnt_d = last_cnt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_insert) begin
      mem_q[cnt_q[AddrW-1:0]] <= value_i;
    end else if (cmd_i.move) begin
      mem_q[best_idx_q] <= rdata_q;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      addr_q   <= '0;
      rvalid_q <= 1'b0;
      found_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      rvalid_q <= issue;
      done_q   <= cmd_i.emit;
      if (cmd_i.load_take) begin
        addr_q  <= '0;
        found_q <= 1'b0;
      end else begin
        if (issue) begin
          addr_q <= addr_q + CntW'(1);
        end
        if (hit) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_take) begin
      lim_q <= value_i;
    end
    if (issue) begin
      rd_idx_q <= addr_q[AddrW-1:0];
    end
    if (hit) begin
      best_q     <= rdata_q;
      best_idx_q <= rd_idx_q;
    end
    if (cmd_i.emit) begin
      status_q <= cmd_i.status;
      taken_q  <= (cmd_i.status == smft_pkg::ST_TAKEN) ? best_q : '0;
      occ_q    <= smft_pkg::OCC_W'(cnt_d);
    end
  end

  assign stat_o.full      = (cnt_q == CntW'(CAPACITY));
  assign stat_o.empty     = (cnt_q == '0);
  assign stat_o.scan_done = !more && !rvalid_q;
  assign stat_o.found     = found_q;

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign taken_value_o = taken_q;
  assign occupancy_o   = occ_q;

endmodule

// ===== hw/rtl/sorted_multiset_floor_take.sv =====
`timescale 1ns / 1ps
// Sorted multiset floor-take: insert values, take the greatest value not above a limit.
// An insert, a full insert or a take on an empty store gives its result in the cycle after
// acceptance, and a new transaction may start in that cycle. A take over n stored values
// scans one entry per cycle; if nothing qualifies it reports no match, else it reads the last
// entry and fills the hole with it; its result comes with busy low again.
// Reset clears the count and control state; the receiver cannot stall results.
module sorted_multiset_floor_take #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [31:0] value_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] taken_value_o,
  output logic [10:0] occupancy_o
);

  smft_pkg::dp_cmd_t  dp_cmd;
  smft_pkg::dp_stat_t dp_stat;

  smft_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .stat_i (dp_stat),
    .cmd_o  (dp_cmd),
    .busy   (busy)
  );

  smft_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (value_i),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .done_o        (done_o),
    .status_o      (status_o),
    .taken_value_o (taken_value_o),
    .occupancy_o   (occupancy_o)
  );

`ifndef SYNTH
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (done_o || busy))
    else $error("accepted transaction neither finished nor kept the block busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result delivered while the block is still busy");

  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != smft_pkg::ST_TAKEN)) |-> (taken_value_o == '0))
    else $error("nonzero taken value on a result without a match");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == smft_pkg::ST_FULL)) |-> (occupancy_o == smft_pkg::OCC_W'(CAPACITY)))
    else $error("store reported full below capacity");
`endif

endmodule

// ===== dv/sorted_multiset_floor_take_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the sorted multiset floor-take block.
// Drives insert and take transactions and checks every result against a sorted price book.
// Depends on smft_pkg and sorted_multiset_floor_take.
module sorted_multiset_floor_take_test;

  localparam int unsigned CAPACITY     = 1024;
  localparam int unsigned SMALL_ORDERS = 60;
  localparam int unsigned CLOSE_ORDERS = 40;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned PRINT_LIMIT  = 50;

  typedef struct packed {
    logic        cmd;
    logic [31:0] value;
  } price_order_t;

  typedef struct packed {
    smft_pkg::status_e status;
    logic [31:0]       taken;
    logic [10:0]       occ;
  } take_outcome_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cmd_i = smft_pkg::CMD_INSERT;
  logic [31:0] value_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [31:0] taken_value_o;
  logic [10:0] occupancy_o;

  logic [31:0]   price_book[$];
  price_order_t  order_q[$];
  take_outcome_t expected_q[$];
  price_order_t  next_order;
  take_outcome_t want;
  logic          handed_off = 1'b0;
  logic          steady = 1'b0;
  int unsigned   queued_n = 0;
  int unsigned   accepted_n = 0;
  int unsigned   cycle_n = 0;
  int unsigned   errors = 0;

  sorted_multiset_floor_take #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .taken_value_o(taken_value_o),
    .occupancy_o  (occupancy_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Updates the price book for one transaction and returns the result it must give.
  function automatic take_outcome_t apply_order(logic cmd, logic [31:0] price);
    take_outcome_t res;
    int slot;
    slot = price_book.size();
    while (slot > 0 && price_book[slot - 1] > price) slot--;
    res.taken = '0;
    if (cmd == smft_pkg::CMD_INSERT) begin
      if (price_book.size() >= CAPACITY) begin
        res.status = smft_pkg::ST_FULL;
      end else begin
        price_book.insert(slot, price);
        res.status = smft_pkg::ST_INSERTED;
      end
    end else if (slot == 0) begin
      res.status = smft_pkg::ST_NOMATCH;
    end else begin
      res.taken = price_book[slot - 1];
      price_book.delete(slot - 1);
      res.status = smft_pkg::ST_TAKEN;
    end
    res.occ = 11'(price_book.size());
    return res;
  endfunction

  function automatic logic [31:0] pick_price();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return '0;
    if (roll < 16) return '1;
    if (roll < 60) return $urandom_range(0, 63);
    return $urandom;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    if (errors < PRINT_LIMIT) begin
      $display("mismatch in %s: got %0h, expected %0h, cycle %0d", what, got, exp_val,
               cycle_n);
    end
    errors++;
  endtask

  task automatic queue_order(logic cmd, logic [31:0] price);
    while (order_q.size() >= 2) @(posedge clk_i);
    order_q.insert(order_q.size(), price_order_t'{cmd: cmd, value: price});
    queued_n++;
  endtask

  task automatic settle();
    while (accepted_n != queued_n || expected_q.size() != 0) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !handed_off) begin
      start <= 1'b1;
    end else if (order_q.size() != 0 && (steady || $urandom_range(0, 99) >= 34)) begin
      next_order = order_q.pop_front();
      start   <= 1'b1;
      cmd_i   <= next_order.cmd;
      value_i <= next_order.value;
    end else begin
      start   <= 1'b0;
      cmd_i   <= 1'($urandom_range(0, 1));
      value_i <= $urandom;
    end
  end

  // A result sampled at an edge belongs to an earlier transaction, so it is checked
  // before the transaction accepted at the same edge is added.
  always @(posedge clk_i) begin
    handed_off = 1'b0;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result, taken value", taken_value_o, '0);
        end else begin
          want = expected_q.pop_front();
          if (status_o !== want.status) begin
            report_mismatch("status", 32'(status_o), 32'(want.status));
          end
          if (taken_value_o !== want.taken) begin
            report_mismatch("taken value", taken_value_o, want.taken);
          end
          if (occupancy_o !== want.occ) begin
            report_mismatch("occupancy", 32'(occupancy_o), 32'(want.occ));
          end
        end
      end
      if (start && busy === 1'b0) begin
        handed_off = 1'b1;
        expected_q.insert(expected_q.size(), apply_order(cmd_i, value_i));
        accepted_n++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_n++;
    if (cycle_n > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_n);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned take_pct;
    int unsigned fill_n;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty store, extremes, duplicates and takes that find nothing below the limit.
    queue_order(smft_pkg::CMD_TAKE, '0);
    queue_order(smft_pkg::CMD_TAKE, '1);
    queue_order(smft_pkg::CMD_INSERT, 32'd5);
    queue_order(smft_pkg::CMD_INSERT, 32'd5);
    queue_order(smft_pkg::CMD_INSERT, '0);
    queue_order(smft_pkg::CMD_INSERT, '1);
    queue_order(smft_pkg::CMD_INSERT, 32'd100);
    queue_order(smft_pkg::CMD_TAKE, 32'd4);
    queue_order(smft_pkg::CMD_TAKE, 32'd4);
    queue_order(smft_pkg::CMD_TAKE, 32'd5);
    queue_order(smft_pkg::CMD_TAKE, 32'd5);
    queue_order(smft_pkg::CMD_TAKE, 32'd5);
    queue_order(smft_pkg::CMD_TAKE, 32'd99);
    queue_order(smft_pkg::CMD_TAKE, 32'hFFFF_FFFE);
    queue_order(smft_pkg::CMD_TAKE, '1);
    queue_order(smft_pkg::CMD_TAKE, '1);
    queue_order(smft_pkg::CMD_INSERT, 32'h7FFF_FFFF);
    queue_order(smft_pkg::CMD_INSERT, 32'h8000_0000);
    queue_order(smft_pkg::CMD_TAKE, 32'h8000_0000);
    queue_order(smft_pkg::CMD_TAKE, '0);
    queue_order(smft_pkg::CMD_TAKE, '1);

    // Mixed traffic on a small store keeps takes short.
    for (int k = 0; k < SMALL_ORDERS; k++) begin
      if (price_book.size() < 4) take_pct = 25;
      else if (price_book.size() > 40) take_pct = 75;
      else take_pct = 50;
      queue_order(($urandom_range(0, 99) < take_pct) ? smft_pkg::CMD_TAKE
                                                     : smft_pkg::CMD_INSERT, pick_price());
    end

    // Fill the store to capacity, then work close to full.
    settle();
    fill_n = CAPACITY - price_book.size();
    for (int k = 0; k < fill_n; k++) begin
      steady = (k >= 300 && k < 600);
      queue_order(smft_pkg::CMD_INSERT, pick_price());
    end
    steady = 1'b0;
    queue_order(smft_pkg::CMD_INSERT, pick_price());
    queue_order(smft_pkg::CMD_INSERT, '1);
    for (int k = 0; k < CLOSE_ORDERS; k++) begin
      queue_order($urandom_range(0, 1) ? smft_pkg::CMD_TAKE : smft_pkg::CMD_INSERT,
                  pick_price());
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    while (expected_q.size() != 0) begin
      want = expected_q.pop_front();
      report_mismatch("missing result, occupancy", '0, 32'(want.occ));
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
